// ----- hw/rtl/sdpr_pkg.sv -----
// shared constants, codes and types of the sysex data packet receiver
`default_nettype none

package sdpr_pkg;

   localparam int FRAME_MAX_DEF   = 256;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [7:0] BYTE_SOX        = 8'hF0;
   localparam logic [7:0] BYTE_EOX        = 8'hF7;
   localparam logic [7:0] ID_UNIVERSAL    = 8'h7E;
   localparam logic [7:0] SUB_FILE_DUMP   = 8'h07;
   localparam logic [7:0] SUB_DATA_PACKET = 8'h02;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_NAK  = 2'd2;

   typedef enum logic [2:0] {
      OP_OPEN,
      OP_FOLD,
      OP_MSB,
      OP_DATA,
      OP_EOX,
      OP_NAK
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sdpr_front.sv -----
// front end: frame tracking, header checks and command generation
`default_nettype none

module sdpr_front #(
   parameter int FRAME_MAX = sdpr_pkg::FRAME_MAX_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_rx_byte,
   input  wire logic              q_full,
   output logic                   q_push,
   output sdpr_pkg::cmd_type      q_cmd
);
   import sdpr_pkg::*;

   localparam int POS_W = $clog2(FRAME_MAX);
   localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_SUB1 = POS_W'(5);
   localparam logic [POS_W-1:0] POS_SUB2 = POS_W'(6);
   localparam logic [POS_W-1:0] POS_PKT  = POS_W'(7);
   localparam logic [POS_W-1:0] POS_LEN  = POS_W'(8);
   localparam logic [POS_W-1:0] POS_PAY  = POS_W'(9);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_MAX - 1);

   logic             in_frame_ff, in_frame_in;
   logic             is_data_ff, is_data_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       pkt_ff, pkt_in;
   logic [7:0]       len_ff, len_in;

   logic             accept;
   logic             header_done;
   logic [POS_W-1:0] k;

   assign req_stall   = q_full;
   assign accept      = req_valid && !q_full;
   assign header_done = is_data_ff && (pos_ff >= POS_PKT);
   assign k           = pos_ff - POS_PAY;

   always_comb begin
      in_frame_in = in_frame_ff;
      is_data_in  = is_data_ff;
      pos_in      = pos_ff;
      pkt_in      = pkt_ff;
      len_in      = len_ff;
      q_push      = 1'b0;
      q_cmd.op    = OP_FOLD;
      q_cmd.data  = req_rx_byte;
      if (accept) begin
         if (!in_frame_ff) begin
            if (req_rx_byte == BYTE_SOX) begin
               in_frame_in = 1'b1;
               pos_in      = POS_ONE;
               is_data_in  = 1'b0;
               pkt_in      = 8'd0;
               len_in      = 8'd0;
               q_push      = 1'b1;
               q_cmd.op    = OP_OPEN;
            end
         end else if (req_rx_byte == BYTE_EOX) begin
            in_frame_in = 1'b0;
            q_push      = header_done;
            q_cmd.op    = OP_EOX;
            q_cmd.data  = pkt_ff;
         end else if (pos_ff >= POS_LAST) begin
            in_frame_in = 1'b0;
            q_push      = header_done;
            q_cmd.op    = OP_NAK;
            q_cmd.data  = pkt_ff;
         end else begin
            pos_in = pos_ff + POS_ONE;
            q_push = 1'b1;
            if (pos_ff == POS_ONE) begin
               is_data_in = (req_rx_byte == ID_UNIVERSAL);
            end else if (pos_ff == POS_SUB1) begin
               if (req_rx_byte != SUB_FILE_DUMP) is_data_in = 1'b0;
            end else if (pos_ff == POS_SUB2) begin
               if (req_rx_byte != SUB_DATA_PACKET) is_data_in = 1'b0;
            end else if (pos_ff == POS_PKT) begin
               pkt_in = req_rx_byte;
            end else if (pos_ff == POS_LEN) begin
               len_in = req_rx_byte;
            end else if (pos_ff >= POS_PAY && is_data_ff) begin
               if (9'(k) <= {1'b0, len_ff}) begin
                  q_cmd.op = (k[2:0] == 3'd0) ? OP_MSB : OP_DATA;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         is_data_ff  <= 1'b0;
         pos_ff      <= '0;
         pkt_ff      <= 8'd0;
         len_ff      <= 8'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         is_data_ff  <= is_data_in;
         pos_ff      <= pos_in;
         pkt_ff      <= pkt_in;
         len_ff      <= len_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sdpr_queue.sv -----
// short command queue between front and back end
`default_nettype none

module sdpr_queue #(
   parameter int QUEUE_DEPTH = sdpr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sdpr_pkg::cmd_type push_cmd,
   output logic                   full,
   output logic                   head_valid,
   output sdpr_pkg::cmd_type      head_cmd,
   input  wire logic              pop
);
   import sdpr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   logic do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         if (do_pop)  rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         if (do_push && !do_pop)      count_ff <= count_ff + CNT_W'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CNT_W'(1);
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sdpr_back.sv -----
// back end: checksum, 8-to-7 unpacking and registered result word
`default_nettype none

module sdpr_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire sdpr_pkg::cmd_type head_cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_value,
   output logic [6:0]             rsp_out_index
);
   import sdpr_pkg::*;

   logic [7:0] xor_ff, xor_in;
   logic [6:0] msb_ff, msb_in;
   logic [6:0] count_ff, count_in;
   logic       valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] value_ff, value_in;
   logic [6:0] index_ff, index_in;

   logic out_free, makes_word;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      case (head_cmd.op)
         OP_DATA, OP_EOX, OP_NAK: makes_word = 1'b1;
         default:                 makes_word = 1'b0;
      endcase
   end

   assign pop = head_valid && (out_free || !makes_word);

   always_comb begin
      xor_in   = xor_ff;
      msb_in   = msb_ff;
      count_in = count_ff;
      valid_in = valid_ff && rsp_stall;
      kind_in  = kind_ff;
      value_in = value_ff;
      index_in = index_ff;
      if (pop) begin
         case (head_cmd.op)
            OP_OPEN: begin
               xor_in   = 8'd0;
               msb_in   = 7'd0;
               count_in = 7'd0;
            end
            OP_FOLD: begin
               xor_in = xor_ff ^ head_cmd.data;
            end
            OP_MSB: begin
               xor_in = xor_ff ^ head_cmd.data;
               msb_in = head_cmd.data[6:0];
            end
            OP_DATA: begin
               xor_in   = xor_ff ^ head_cmd.data;
               valid_in = 1'b1;
               kind_in  = KIND_DATA;
               value_in = head_cmd.data | {msb_ff[0], 7'd0};
               index_in = count_ff;
               msb_in   = {1'b0, msb_ff[6:1]};
               count_in = count_ff + 7'd1;
            end
            OP_EOX: begin
               valid_in = 1'b1;
               kind_in  = (xor_ff == 8'd0) ? KIND_ACK : KIND_NAK;
               value_in = head_cmd.data;
               index_in = 7'd0;
            end
            OP_NAK: begin
               valid_in = 1'b1;
               kind_in  = KIND_NAK;
               value_in = head_cmd.data;
               index_in = 7'd0;
            end
            default: begin
               xor_in = xor_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_ff   <= 8'd0;
         msb_ff   <= 7'd0;
         count_ff <= 7'd0;
         valid_ff <= 1'b0;
      end else begin
         xor_ff   <= xor_in;
         msb_ff   <= msb_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      kind_ff  <= kind_in;
      value_ff <= value_in;
      index_ff <= index_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_value     = value_ff;
   assign rsp_out_index = index_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sysex_data_packet_receiver.sv -----
// top level of the sysex data packet receiver
//
// channel   dir  handshake            payload
// req_      in   req_valid/req_stall  req_rx_byte[7:0]
// rsp_      out  rsp_valid/rsp_stall  rsp_kind[1:0] rsp_value[7:0] rsp_out_index[6:0]
//
// one byte per cycle while req_stall is low; a result word passes the queue and the
// result register; the front end folds each byte into the frame state; the back end
// drains one command per cycle; a word-making command needs a free result register
// synchronous active-high reset clears frame state, queue and result valid
// req_stall rises only when the command queue is full; rsp_stall backs up the queue
`default_nettype none

module sysex_data_packet_receiver #(
   parameter int FRAME_MAX   = sdpr_pkg::FRAME_MAX_DEF,
   parameter int QUEUE_DEPTH = sdpr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_value,
   output logic [6:0]      rsp_out_index
);
   import sdpr_pkg::*;

   logic    q_full, q_push, head_valid, pop;
   cmd_type push_cmd, head_cmd;

   sdpr_front #(.FRAME_MAX(FRAME_MAX)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   sdpr_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   sdpr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_cmd      (head_cmd),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_value     (rsp_value),
      .rsp_out_index (rsp_out_index)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/sdpr_checker.sv -----
// port-level checks of the sysex data packet receiver and their bind
`default_nettype none

module sdpr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_value,
   input wire logic [6:0] rsp_out_index
);
   import sdpr_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled right after reset");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_DATA || rsp_kind == KIND_ACK || rsp_kind == KIND_NAK))
      else $error("undefined result kind");

   a_report_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_DATA) |-> (rsp_out_index == 7'd0))
      else $error("ack or nak with nonzero index");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_kind) && $stable(rsp_value) && $stable(rsp_out_index)))
      else $error("stalled result word changed");

endmodule

bind sysex_data_packet_receiver sdpr_checker u_sdpr_checker (.*);

`default_nettype wire
